[src/arp_pkg.sv]
// Shared types and codes for the modem response parser.
package arp_pkg;

	// characters of the response grammar
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_O    = 8'h4F;
	localparam logic [7:0] CH_K    = 8'h4B;
	localparam logic [7:0] CH_E    = 8'h45;
	localparam logic [7:0] CH_R    = 8'h52;

	// byte classes produced by the front end
	localparam logic [3:0] CLS_CR    = 4'd0;
	localparam logic [3:0] CLS_LF    = 4'd1;
	localparam logic [3:0] CLS_PLUS  = 4'd2;
	localparam logic [3:0] CLS_O     = 4'd3;
	localparam logic [3:0] CLS_K     = 4'd4;
	localparam logic [3:0] CLS_E     = 4'd5;
	localparam logic [3:0] CLS_R     = 4'd6;
	localparam logic [3:0] CLS_PRINT = 4'd7;
	localparam logic [3:0] CLS_OTHER = 4'd8;

	// parser states
	localparam logic [4:0] ST_START = 5'd0;
	localparam logic [4:0] ST_LF1   = 5'd1;
	localparam logic [4:0] ST_FIRST = 5'd2;
	localparam logic [4:0] ST_PLUS  = 5'd3;
	localparam logic [4:0] ST_DLF   = 5'd4;
	localparam logic [4:0] ST_NEXT  = 5'd5;
	localparam logic [4:0] ST_ELF   = 5'd6;
	localparam logic [4:0] ST_VALUE = 5'd7;
	localparam logic [4:0] ST_O     = 5'd8;
	localparam logic [4:0] ST_OK    = 5'd9;
	localparam logic [4:0] ST_OKCR  = 5'd10;
	localparam logic [4:0] ST_E     = 5'd12;
	localparam logic [4:0] ST_ER    = 5'd13;
	localparam logic [4:0] ST_ERR   = 5'd14;
	localparam logic [4:0] ST_ERRO  = 5'd15;
	localparam logic [4:0] ST_ERROR = 5'd16;
	localparam logic [4:0] ST_ERRCR = 5'd17;
	localparam logic [4:0] ST_TEXT  = 5'd18;

	// outcome codes
	localparam logic [1:0] OUT_BUSY  = 2'd0;
	localparam logic [1:0] OUT_SYNTAX = 2'd1;
	localparam logic [1:0] OUT_OK    = 2'd2;
	localparam logic [1:0] OUT_ERROR = 2'd3;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [3:0] cls;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		logic [1:0] outcome;
		logic       store_write;
		logic [3:0] store_line;
		logic [5:0] store_column;
		logic [7:0] store_char;
		logic [4:0] lines_found;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

[src/arp_queue.sv]
// Small synchronous FIFO used between the parser stages and at the output.
module arp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

[src/arp_front.sv]
// Front end: takes received bytes, classifies them and queues them for the parser.
module arp_front import arp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       item_valid,
	input  logic       item_pop,
	output item_t      item
);
	item_t            cls_item;
	logic             q_empty;
	logic [ITEM_W-1:0] q_rdata;

	always_comb begin
		cls_item.ch = rx_byte;
		unique case (rx_byte)
			CH_CR:   cls_item.cls = CLS_CR;
			CH_LF:   cls_item.cls = CLS_LF;
			CH_PLUS: cls_item.cls = CLS_PLUS;
			CH_O:    cls_item.cls = CLS_O;
			CH_K:    cls_item.cls = CLS_K;
			CH_E:    cls_item.cls = CLS_E;
			CH_R:    cls_item.cls = CLS_R;
			default: begin
				if (rx_byte >= 8'h20 && rx_byte <= 8'h7E) begin
					cls_item.cls = CLS_PRINT;
				end else begin
					cls_item.cls = CLS_OTHER;
				end
			end
		endcase
	end

	arp_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_item_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (cls_item),
		.pop   (item_pop),
		.empty (q_empty),
		.rdata (q_rdata)
	);

	assign item_valid = !q_empty;
	assign item       = item_t'(q_rdata);

endmodule

[src/arp_back.sv]
// Back end: grammar state machine, line/column tracking and buffer write reporting.
module arp_back import arp_pkg::*; #(
	parameter int LINE_CAPACITY = 16,
	parameter int LINE_LENGTH   = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_pop,
	input  item_t   item,
	output logic    res_push,
	input  logic    res_full,
	output result_t res
);
	localparam int LCW = $clog2(LINE_CAPACITY + 1);
	localparam int CCW = $clog2(LINE_LENGTH);

	logic [4:0]     state_q;
	logic [LCW-1:0] line_q;
	logic [CCW-1:0] col_q;

	logic [4:0]     state_n;
	logic [LCW-1:0] line_n;
	logic [CCW-1:0] col_n;
	logic           ok;
	logic [1:0]     fin;
	logic           wr;
	logic [7:0]     wr_char;
	logic           printable;
	logic           line_room;
	logic           col_room;
	logic           fire;
	logic [LCW+4:0] line_ext;
	logic [CCW+5:0] col_ext;

	assign fire      = item_valid && !res_full;
	assign item_pop  = fire;
	assign res_push  = fire;
	assign printable = (item.cls != CLS_CR) && (item.cls != CLS_LF) && (item.cls != CLS_OTHER);
	assign line_room = (line_q < LCW'(LINE_CAPACITY));
	assign col_room  = (col_q < CCW'(LINE_LENGTH - 1));

	always_comb begin
		state_n = ST_START;
		line_n  = line_q;
		col_n   = col_q;
		ok      = 1'b0;
		fin     = OUT_BUSY;
		wr      = 1'b0;
		wr_char = item.ch;
		unique case (state_q) inside
			ST_START: begin
				line_n = '0;
				col_n  = '0;
				if (item.cls == CLS_CR) begin
					state_n = ST_LF1;
					ok      = 1'b1;
				end
			end
			ST_LF1: begin
				if (item.cls == CLS_LF) begin
					state_n = ST_FIRST;
					ok      = 1'b1;
				end
			end
			ST_FIRST: begin
				if (item.cls == CLS_PLUS) begin
					state_n = ST_PLUS;
					ok      = 1'b1;
				end else if (item.cls == CLS_O) begin
					state_n = ST_O;
					ok      = 1'b1;
				end else if (item.cls == CLS_E) begin
					state_n = ST_E;
					ok      = 1'b1;
				end
			end
			ST_PLUS, ST_TEXT: begin
				if (state_q == ST_TEXT && item.cls == CLS_CR) begin
					state_n = ST_DLF;
					ok      = 1'b1;
					wr      = line_room;
					wr_char = 8'h00;
					col_n   = '0;
					if (line_room) begin
						line_n = line_q + 1'b1;
					end
				end else if (printable) begin
					state_n = ST_TEXT;
					ok      = 1'b1;
					if (line_room && col_room) begin
						wr    = 1'b1;
						col_n = col_q + 1'b1;
					end
				end
			end
			ST_DLF: begin
				if (item.cls == CLS_LF) begin
					state_n = ST_NEXT;
					ok      = 1'b1;
				end
			end
			ST_NEXT: begin
				if (item.cls == CLS_CR) begin
					state_n = ST_ELF;
					ok      = 1'b1;
				end else if (item.cls == CLS_PLUS) begin
					state_n = ST_PLUS;
					ok      = 1'b1;
				end
			end
			ST_ELF: begin
				if (item.cls == CLS_LF) begin
					state_n = ST_VALUE;
					ok      = 1'b1;
				end
			end
			ST_VALUE: begin
				if (item.cls == CLS_O) begin
					state_n = ST_O;
					ok      = 1'b1;
				end else if (item.cls == CLS_E) begin
					state_n = ST_E;
					ok      = 1'b1;
				end
			end
			ST_O: begin
				if (item.cls == CLS_K) begin
					state_n = ST_OK;
					ok      = 1'b1;
				end
			end
			ST_OK: begin
				if (item.cls == CLS_CR) begin
					state_n = ST_OKCR;
					ok      = 1'b1;
				end
			end
			ST_OKCR: begin
				if (item.cls == CLS_LF) begin
					state_n = ST_START;
					ok      = 1'b1;
					fin     = OUT_OK;
				end
			end
			ST_E: begin
				if (item.cls == CLS_R) begin
					state_n = ST_ER;
					ok      = 1'b1;
				end
			end
			ST_ER: begin
				if (item.cls == CLS_R) begin
					state_n = ST_ERR;
					ok      = 1'b1;
				end
			end
			ST_ERR: begin
				if (item.cls == CLS_O) begin
					state_n = ST_ERRO;
					ok      = 1'b1;
				end
			end
			ST_ERRO: begin
				if (item.cls == CLS_R) begin
					state_n = ST_ERROR;
					ok      = 1'b1;
				end
			end
			ST_ERROR: begin
				if (item.cls == CLS_CR) begin
					state_n = ST_ERRCR;
					ok      = 1'b1;
				end
			end
			ST_ERRCR: begin
				if (item.cls == CLS_LF) begin
					state_n = ST_START;
					ok      = 1'b1;
					fin     = OUT_ERROR;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (!ok) begin
			state_n = ST_START;
			wr      = 1'b0;
			fin     = OUT_BUSY;
		end
	end

	assign line_ext = {5'd0, line_q};
	assign col_ext  = {6'd0, col_q};

	always_comb begin
		res.outcome      = ok ? fin : OUT_SYNTAX;
		res.store_write  = wr;
		res.store_line   = wr ? line_ext[3:0] : 4'd0;
		res.store_column = wr ? col_ext[5:0] : 6'd0;
		res.store_char   = wr ? wr_char : 8'd0;
		res.lines_found  = (ok && fin != OUT_BUSY) ? line_ext[4:0] : 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			line_q  <= '0;
			col_q   <= '0;
		end else if (fire) begin
			state_q <= state_n;
			line_q  <= line_n;
			col_q   <= col_n;
		end
	end

	a_line_cap: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LCW'(LINE_CAPACITY))
		else $error("line counter above capacity");

	a_col_cap: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CCW'(LINE_LENGTH - 1))
		else $error("column index above line length");

	a_final_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.outcome == OUT_OK || res.outcome == OUT_ERROR) |-> !res.store_write)
		else $error("buffer write on final outcome");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q) && $stable(line_q) && $stable(col_q))
		else $error("parser state moved without a beat");

endmodule

[src/at_response_parser_top.sv]
// Top level of the modem response parser: front classifier, parser back end, result queue.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------
//  input    | push / full       | rx_byte
//  result   | empty / pop       | outcome, store_write, store_line, store_column,
//           |                   | store_char, lines_found
//
// One beat per cycle sustained while the result side keeps popping; a byte reaches the result
// ports through the front queue register, then the result queue register.
// The parser state machine takes one byte per update; it advances whenever the front
// queue holds a byte and the result queue has room.
// Reset clears the parser state, counters and both queues.
// A stalled result side fills the result queue, then the front queue, then raises full.
module at_response_parser_top import arp_pkg::*; #(
	parameter int LINE_CAPACITY = 16,
	parameter int LINE_LENGTH   = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] outcome,
	output logic       store_write,
	output logic [3:0] store_line,
	output logic [5:0] store_column,
	output logic [7:0] store_char,
	output logic [4:0] lines_found
);
	logic              item_valid;
	logic              item_pop;
	item_t             item;
	logic              res_push;
	logic              res_full;
	result_t           res;
	logic [RESULT_W-1:0] res_rdata;
	result_t           res_out;

	arp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.item_valid(item_valid),
		.item_pop  (item_pop),
		.item      (item)
	);

	arp_back #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.LINE_LENGTH  (LINE_LENGTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_pop  (item_pop),
		.item      (item),
		.res_push  (res_push),
		.res_full  (res_full),
		.res       (res)
	);

	arp_queue #(
		.WIDTH(RESULT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.wdata (res),
		.pop   (pop),
		.empty (empty),
		.rdata (res_rdata)
	);

	assign res_out      = result_t'(res_rdata);
	assign outcome      = res_out.outcome;
	assign store_write  = res_out.store_write;
	assign store_line   = res_out.store_line;
	assign store_column = res_out.store_column;
	assign store_char   = res_out.store_char;
	assign lines_found  = res_out.lines_found;

endmodule

[tb/sv/at_response_monitor.sv]
// Watches both queue ports of the response parser, predicts each result beat and compares.
module at_response_monitor import arp_pkg::*; #(
	parameter int LINE_CAPACITY = 16,
	parameter int LINE_LENGTH   = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] rx_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic [1:0] outcome,
	input  logic       store_write,
	input  logic [3:0] store_line,
	input  logic [5:0] store_column,
	input  logic [7:0] store_char,
	input  logic [4:0] lines_found,
	output int         fail_count,
	output int         pending,
	output int         ok_seen,
	output int         err_seen,
	output int         syntax_seen,
	output int         writes_seen
);

	logic [4:0] parse_st;
	int         line_cnt;
	int         col_idx;
	result_t    pending_results[$];
	result_t    got;
	result_t    want;

	function automatic logic is_print(input logic [7:0] c);
		return c >= 8'h20 && c <= 8'h7E;
	endfunction

	function automatic string show_res(input result_t r);
		return $sformatf("outcome=%0d write=%0b line=%0d col=%0d char=%02h lines=%0d",
			r.outcome, r.store_write, r.store_line, r.store_column, r.store_char,
			r.lines_found);
	endfunction

	task automatic emit_store(inout result_t r, input logic [7:0] c, input logic is_char);
		if (line_cnt < LINE_CAPACITY && !(is_char && col_idx >= LINE_LENGTH - 1)) begin
			r.store_write  = 1'b1;
			r.store_line   = line_cnt[3:0];
			r.store_column = col_idx[5:0];
			r.store_char   = c;
			if (is_char)
				col_idx++;
		end
	endtask

	task automatic parse_byte(input logic [7:0] c, output result_t r);
		logic [4:0] nxt;
		logic       ok;
		logic [1:0] fin;
		r   = '0;
		nxt = ST_START;
		ok  = 1'b0;
		fin = OUT_BUSY;
		case (parse_st)
			ST_START: begin
				line_cnt = 0;
				col_idx  = 0;
				if (c == CH_CR) begin nxt = ST_LF1; ok = 1'b1; end
			end
			ST_LF1: if (c == CH_LF) begin nxt = ST_FIRST; ok = 1'b1; end
			ST_FIRST: begin
				if (c == CH_PLUS) begin nxt = ST_PLUS; ok = 1'b1; end
				else if (c == CH_O) begin nxt = ST_O; ok = 1'b1; end
				else if (c == CH_E) begin nxt = ST_E; ok = 1'b1; end
			end
			ST_PLUS: begin
				if (is_print(c)) begin
					nxt = ST_TEXT;
					ok  = 1'b1;
					emit_store(r, c, 1'b1);
				end
			end
			ST_TEXT: begin
				if (c == CH_CR) begin
					nxt = ST_DLF;
					ok  = 1'b1;
					emit_store(r, 8'h00, 1'b0);
					col_idx = 0;
					if (line_cnt < LINE_CAPACITY)
						line_cnt++;
				end else if (is_print(c)) begin
					nxt = ST_TEXT;
					ok  = 1'b1;
					emit_store(r, c, 1'b1);
				end
			end
			ST_DLF: if (c == CH_LF) begin nxt = ST_NEXT; ok = 1'b1; end
			ST_NEXT: begin
				if (c == CH_CR) begin nxt = ST_ELF; ok = 1'b1; end
				else if (c == CH_PLUS) begin nxt = ST_PLUS; ok = 1'b1; end
			end
			ST_ELF: if (c == CH_LF) begin nxt = ST_VALUE; ok = 1'b1; end
			ST_VALUE: begin
				if (c == CH_O) begin nxt = ST_O; ok = 1'b1; end
				else if (c == CH_E) begin nxt = ST_E; ok = 1'b1; end
			end
			ST_O:     if (c == CH_K) begin nxt = ST_OK; ok = 1'b1; end
			ST_OK:    if (c == CH_CR) begin nxt = ST_OKCR; ok = 1'b1; end
			ST_OKCR:  if (c == CH_LF) begin nxt = ST_START; ok = 1'b1; fin = OUT_OK; end
			ST_E:     if (c == CH_R) begin nxt = ST_ER; ok = 1'b1; end
			ST_ER:    if (c == CH_R) begin nxt = ST_ERR; ok = 1'b1; end
			ST_ERR:   if (c == CH_O) begin nxt = ST_ERRO; ok = 1'b1; end
			ST_ERRO:  if (c == CH_R) begin nxt = ST_ERROR; ok = 1'b1; end
			ST_ERROR: if (c == CH_CR) begin nxt = ST_ERRCR; ok = 1'b1; end
			ST_ERRCR: if (c == CH_LF) begin nxt = ST_START; ok = 1'b1; fin = OUT_ERROR; end
			default: ok = 1'b0;
		endcase
		if (!ok) begin
			parse_st  = ST_START;
			r         = '0;
			r.outcome = OUT_SYNTAX;
		end else begin
			parse_st = nxt;
			if (fin != OUT_BUSY) begin
				r.outcome     = fin;
				r.lines_found = (line_cnt <= LINE_CAPACITY) ? line_cnt[4:0]
					: LINE_CAPACITY[4:0];
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_st    = ST_START;
			line_cnt    = 0;
			col_idx     = 0;
			pending_results.delete();
			pending     = 0;
			fail_count  = 0;
			ok_seen     = 0;
			err_seen    = 0;
			syntax_seen = 0;
			writes_seen = 0;
		end else begin
			if (pop && !empty) begin
				got = {outcome, store_write, store_line, store_column, store_char, lines_found};
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result beat: %s", $time, show_res(got));
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						$display("%0t mismatch expected: %s", $time, show_res(want));
						$display("%0t mismatch actual:   %s", $time, show_res(got));
						fail_count++;
					end
					case (want.outcome)
						OUT_OK:     ok_seen++;
						OUT_ERROR:  err_seen++;
						OUT_SYNTAX: syntax_seen++;
						default:    ;
					endcase
					if (want.store_write)
						writes_seen++;
				end
			end
			if (push && !full) begin
				parse_byte(rx_byte, want);
				pending_results.push_back(want);
			end
			pending = pending_results.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
// Top of the parser bench: clock, reset, byte stimulus with random idling, final verdict.
module testbench;
	import arp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 2000;
	localparam int CALM_AFTER  = 1700;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] rx_byte;
	logic       empty;
	logic       pop;
	logic [1:0] outcome;
	logic       store_write;
	logic [3:0] store_line;
	logic [5:0] store_column;
	logic [7:0] store_char;
	logic [4:0] lines_found;

	int fail_count;
	int pending;
	int ok_seen;
	int err_seen;
	int syntax_seen;
	int writes_seen;

	int         cycles     = 0;
	int         items_sent = 0;
	int         pop_hold   = 0;
	bit         in_idle    = 1'b1;
	bit         out_idle   = 1'b1;
	logic [7:0] tx_q[$];

	at_response_parser_top DUT (
		.clk, .arst_n, .push, .full, .rx_byte, .empty, .pop,
		.outcome, .store_write, .store_line, .store_column, .store_char, .lines_found
	);

	at_response_monitor MON (
		.clk, .arst_n, .push, .full, .rx_byte, .empty, .pop,
		.outcome, .store_write, .store_line, .store_column, .store_char, .lines_found,
		.fail_count, .pending, .ok_seen, .err_seen, .syntax_seen, .writes_seen
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (pop_hold > 0) begin
				pop = 1'b0;
				pop_hold--;
			end else if (out_idle && $urandom_range(0, 11) == 0) begin
				pop      = 1'b0;
				pop_hold = $urandom_range(0, 16);
			end else begin
				pop = 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (in_idle && $urandom_range(0, 9) == 0) begin
			push = 1'b0;
			gap  = $urandom_range(1, 17);
			repeat (gap) @(negedge clk);
		end
		push    = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (full);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic flush_tx();
		foreach (tx_q[i])
			send_byte(tx_q[i]);
		tx_q.delete();
	endtask

	task automatic add_crlf();
		tx_q.push_back(CH_CR);
		tx_q.push_back(CH_LF);
	endtask

	task automatic add_final(input bit is_ok);
		if (is_ok) begin
			tx_q.push_back(CH_O);
			tx_q.push_back(CH_K);
		end else begin
			tx_q.push_back(CH_E);
			tx_q.push_back(CH_R);
			tx_q.push_back(CH_R);
			tx_q.push_back(CH_O);
			tx_q.push_back(CH_R);
		end
		add_crlf();
	endtask

	// well-formed response with random content; occasionally many or long lines
	task automatic add_response();
		int nl;
		int len;
		add_crlf();
		nl = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
		for (int l = 0; l < nl; l++) begin
			tx_q.push_back(CH_PLUS);
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
			for (int k = 0; k < len; k++)
				tx_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
			add_crlf();
		end
		if (nl > 0)
			add_crlf();
		add_final(1'($urandom_range(0, 1)));
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
			0:       return CH_CR;
			1:       return CH_LF;
			2:       return CH_PLUS;
			3:       return CH_O;
			4:       return CH_E;
			5:       return CH_R;
			6:       return CH_K;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int pick;
		arst_n  = 1'b0;
		push    = 1'b0;
		rx_byte = 8'h00;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// byte extremes rejected at start
		tx_q.push_back(8'h00);
		tx_q.push_back(8'hFF);
		// one data line with printable extremes, then OK
		add_crlf();
		tx_q.push_back(CH_PLUS);
		tx_q.push_back(8'h20);
		tx_q.push_back(8'h7E);
		add_crlf();
		add_crlf();
		add_final(1'b1);
		// bare ERROR
		add_crlf();
		add_final(1'b0);
		// non-printable right after plus
		add_crlf();
		tx_q.push_back(CH_PLUS);
		tx_q.push_back(8'h7F);
		flush_tx();

		while (items_sent < ITEM_TARGET) begin
			if (items_sent > CALM_AFTER) begin
				in_idle  = 1'b0;
				out_idle = 1'b0;
			end else begin
				in_idle  = $urandom_range(0, 3) != 0;
				out_idle = $urandom_range(0, 3) != 0;
			end
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				repeat ($urandom_range(1, 5))
					tx_q.push_back(noise_byte());
			end else begin
				add_response();
				if (pick < 4)
					tx_q[$urandom_range(0, tx_q.size() - 1)] = noise_byte();
			end
			flush_tx();
		end
		push = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d bytes; %0d OK and %0d ERROR responses, %0d syntax errors,",
			items_sent, ok_seen, err_seen, syntax_seen);
		$display("%0d buffer writes, with random idling on both queue ports.", writes_seen);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
